// File: rtl/ipv4_dp_pkg.sv
// ---------------------------------------------------------------------------
// ipv4_dp_pkg - shared types and constants for the IPv4 dotted-quad parser
// Token format passed from the classifier front end to the parse back end.
// ---------------------------------------------------------------------------
package ipv4_dp_pkg;

    localparam int CHAR_BITS   = 8;
    localparam int ADDR_BITS   = 32;
    localparam int PART_BITS   = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [CHAR_BITS-1:0] CH_ZERO = CHAR_BITS'('h30);
    localparam logic [CHAR_BITS-1:0] CH_NINE = CHAR_BITS'('h39);
    localparam logic [CHAR_BITS-1:0] CH_DOT  = CHAR_BITS'('h2E);

    localparam logic [PART_BITS-1:0] OCTET_MAX = PART_BITS'(255);

    typedef enum logic [1:0] {
        TOK_DIGIT,
        TOK_DOT,
        TOK_OTHER,
        TOK_END
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [3:0]  digit;
    } tok_t;

endpackage

// File: rtl/ipv4_dp_front.sv
// ---------------------------------------------------------------------------
// ipv4_dp_front - character classifier
// Turns each accepted input word into a token and pushes it into the queue.
// ---------------------------------------------------------------------------
module ipv4_dp_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ipv4_dp_pkg::CHAR_BITS-1:0] s_tdata,
    input  logic                             s_tlast,
    output logic                             push_valid,
    input  logic                             push_ready,
    output ipv4_dp_pkg::tok_t                push_tok
);

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_tok.digit = 4'(s_tdata - ipv4_dp_pkg::CH_ZERO);
        if (s_tlast) begin
            push_tok.kind = ipv4_dp_pkg::TOK_END;
        end else if (s_tdata inside {[ipv4_dp_pkg::CH_ZERO:ipv4_dp_pkg::CH_NINE]}) begin
            push_tok.kind = ipv4_dp_pkg::TOK_DIGIT;
        end else if (s_tdata == ipv4_dp_pkg::CH_DOT) begin
            push_tok.kind = ipv4_dp_pkg::TOK_DOT;
        end else begin
            push_tok.kind = ipv4_dp_pkg::TOK_OTHER;
        end
    end

endmodule

// File: rtl/ipv4_dp_queue.sv
// ---------------------------------------------------------------------------
// ipv4_dp_queue - small token FIFO
// Decouples the classifier from the parse back end.
// ---------------------------------------------------------------------------
module ipv4_dp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  ipv4_dp_pkg::tok_t push_tok,
    output logic              pop_valid,
    input  logic              pop_ready,
    output ipv4_dp_pkg::tok_t pop_tok
);

    ipv4_dp_pkg::tok_t mem [ipv4_dp_pkg::QUEUE_DEPTH];

    logic [ipv4_dp_pkg::QUEUE_AW:0] wr_ptr_reg, wr_ptr_next;
    logic [ipv4_dp_pkg::QUEUE_AW:0] rd_ptr_reg, rd_ptr_next;
    logic                           do_push, do_pop;
    logic                           empty, full;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[ipv4_dp_pkg::QUEUE_AW] != rd_ptr_reg[ipv4_dp_pkg::QUEUE_AW]) &&
                   (wr_ptr_reg[ipv4_dp_pkg::QUEUE_AW-1:0] ==
                    rd_ptr_reg[ipv4_dp_pkg::QUEUE_AW-1:0]);

    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign do_push    = push_valid && !full;
    assign do_pop     = pop_ready && !empty;
    assign pop_tok    = mem[rd_ptr_reg[ipv4_dp_pkg::QUEUE_AW-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (ipv4_dp_pkg::QUEUE_AW+1)'(do_push);
    assign rd_ptr_next = rd_ptr_reg + (ipv4_dp_pkg::QUEUE_AW+1)'(do_pop);

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg[ipv4_dp_pkg::QUEUE_AW-1:0]] <= push_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

// File: rtl/ipv4_dp_back.sv
// ---------------------------------------------------------------------------
// ipv4_dp_back - parse state and result register
// Consumes one token per cycle; END tokens load the output register once free.
// ---------------------------------------------------------------------------
module ipv4_dp_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  ipv4_dp_pkg::tok_t                 pop_tok,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ipv4_dp_pkg::ADDR_BITS-1:0] m_tdata,
    output logic                              m_tuser
);

    logic [1:0]                        part_index_reg, part_index_next;
    logic [ipv4_dp_pkg::PART_BITS-1:0] part_value_reg, part_value_next;
    logic [1:0]                        digit_count_reg, digit_count_next;
    logic                              lead_zero_reg, lead_zero_next;
    logic [23:0]                       done_octets_reg, done_octets_next;
    logic                              error_reg, error_next;

    logic                              m_tvalid_reg, m_tvalid_next;
    logic [ipv4_dp_pkg::ADDR_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                              m_tuser_reg, m_tuser_next;

    logic                              out_free, take, part_ok, addr_ok;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign pop_ready = (pop_tok.kind != ipv4_dp_pkg::TOK_END) || out_free;
    assign take      = pop_valid && pop_ready;

    assign part_ok = (digit_count_reg != 2'd0) &&
                     !(lead_zero_reg && digit_count_reg != 2'd1) &&
                     (part_value_reg <= ipv4_dp_pkg::OCTET_MAX);
    assign addr_ok = !error_reg && (part_index_reg == 2'd3) && part_ok;

    always_comb begin
        part_index_next  = part_index_reg;
        part_value_next  = part_value_reg;
        digit_count_next = digit_count_reg;
        lead_zero_next   = lead_zero_reg;
        done_octets_next = done_octets_reg;
        error_next       = error_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        if (take) begin
            case (pop_tok.kind)
                ipv4_dp_pkg::TOK_END: begin
                    m_tvalid_next    = 1'b1;
                    m_tuser_next     = addr_ok;
                    m_tdata_next     = addr_ok ? {done_octets_reg, part_value_reg[7:0]} : '0;
                    part_index_next  = '0;
                    part_value_next  = '0;
                    digit_count_next = '0;
                    lead_zero_next   = 1'b0;
                    done_octets_next = '0;
                    error_next       = 1'b0;
                end
                ipv4_dp_pkg::TOK_DIGIT: begin
                    if (!error_reg) begin
                        if (digit_count_reg == 2'd3) begin
                            error_next = 1'b1;
                        end else begin
                            if (digit_count_reg == 2'd0) begin
                                lead_zero_next = (pop_tok.digit == 4'd0);
                            end
                            // x10 as shift-add, wraps at 10 bits
                            part_value_next = (part_value_reg << 3) + (part_value_reg << 1) +
                                              ipv4_dp_pkg::PART_BITS'(pop_tok.digit);
                            digit_count_next = digit_count_reg + 2'd1;
                        end
                    end
                end
                ipv4_dp_pkg::TOK_DOT: begin
                    if (!error_reg) begin
                        if (!part_ok || part_index_reg == 2'd3) begin
                            error_next = 1'b1;
                        end else begin
                            done_octets_next = {done_octets_reg[15:0], part_value_reg[7:0]};
                            part_index_next  = part_index_reg + 2'd1;
                            part_value_next  = '0;
                            digit_count_next = '0;
                            lead_zero_next   = 1'b0;
                        end
                    end
                end
                default: begin
                    error_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_index_reg  <= '0;
            part_value_reg  <= '0;
            digit_count_reg <= '0;
            lead_zero_reg   <= 1'b0;
            done_octets_reg <= '0;
            error_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            part_index_reg  <= part_index_next;
            part_value_reg  <= part_value_next;
            digit_count_reg <= digit_count_next;
            lead_zero_reg   <= lead_zero_next;
            done_octets_reg <= done_octets_next;
            error_reg       <= error_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/ipv4_dotted_decimal_parser_unit.sv
// ---------------------------------------------------------------------------
// ipv4_dotted_decimal_parser_unit - strict dotted-quad IPv4 text parser
// Character stream in, one (valid, address) word out per end-of-text word.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                | tlast        | tuser
//  s_      | in  | [7:0] character      | end_of_text  | -
//  m_      | out | [31:0] address       | -            | [0] valid_res
//
//  One input word per cycle sustained while results are taken; a 4-entry token
//  queue sits between the classifier and the parse state.
//  An end-of-text token goes through the queue, then loads the output register.
//  Only an end-of-text token stalls the back end, while the output register
//  still holds an untaken word; words behind it fill the queue, then s_tready drops.
//  aresetn is synchronous, active low; the block takes words the cycle after.
module ipv4_dotted_decimal_parser_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ipv4_dp_pkg::CHAR_BITS-1:0]  s_tdata,   // [7:0] character
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ipv4_dp_pkg::ADDR_BITS-1:0]  m_tdata,   // [31:0] address
    output logic                               m_tuser    // [0] valid_res
);

    logic              push_valid, push_ready, pop_valid, pop_ready;
    ipv4_dp_pkg::tok_t push_tok, pop_tok;

    ipv4_dp_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tok   (push_tok)
    );

    ipv4_dp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tok   (push_tok),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_tok    (pop_tok)
    );

    ipv4_dp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_tok   (pop_tok),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: rtl/ipv4_dp_checker.sv
// ---------------------------------------------------------------------------
// ipv4_dp_checker - port-level assertions for the parser unit
// Bound to the top level; sees its ports only.
// ---------------------------------------------------------------------------
module ipv4_dp_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [ipv4_dp_pkg::ADDR_BITS-1:0]  m_tdata,
    input logic                               m_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // rejected text reports a zero address
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid text with nonzero address");

    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

endmodule

bind ipv4_dotted_decimal_parser_unit ipv4_dp_checker u_ipv4_dp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: bench/tb_ipv4_dotted_decimal_parser_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ipv4_dotted_decimal_parser_unit - self-checking bench for the parser
// Texts go in one character word at a time, each closed by an end-of-text
// word. A cycle-free model of the parse state predicts the (valid, address)
// word for every end marker, and output words are compared in order. A fixed
// table of texts runs first, then random texts, half well formed and the rest
// empty or damaged, under random stalls on both channels.
// ---------------------------------------------------------------------------
module tb_ipv4_dotted_decimal_parser_unit;

    localparam int RESET_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAIN_WORDS   = 1000;
    localparam int TOTAL_WORDS  = 1200;
    localparam int N_ROWS       = 23;

    typedef struct packed {
        logic        ok;
        logic [31:0] addr;
    } addr_result_t;

    typedef struct packed {
        logic         fixed;   // 1: use res below instead of the model
        addr_result_t res;
    } pinned_result_t;

    typedef struct {
        string        text;
        bit           fixed;
        logic         ok;
        logic [31:0]  addr;
    } text_row_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [ipv4_dp_pkg::CHAR_BITS-1:0] s_tdata;
    logic                              s_tlast;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [ipv4_dp_pkg::ADDR_BITS-1:0] m_tdata;
    logic                              m_tuser;

    ipv4_dotted_decimal_parser_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // parse state of the model
    logic [1:0]  prt_idx;
    logic [9:0]  prt_val;
    logic [1:0]  dig_cnt;
    logic        lead_zero;
    logic [23:0] octets_done;
    logic        text_bad;

    addr_result_t   addr_expect_q [$];
    pinned_result_t pinned_q [$];
    logic [7:0]     text_q [$];

    int  fail_count  = 0;
    int  words_sent  = 0;
    bit  tx_idle     = 1'b0;
    bit  rx_idle     = 1'b0;
    bit  rx_hold_req = 1'b0;

    text_row_t text_rows [N_ROWS] = '{
        '{"",                1'b1, 1'b0, 32'h0},
        '{"0.0.0.0",         1'b1, 1'b1, 32'h0},
        '{"255.255.255.255", 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{"1.2.3.4",         1'b1, 1'b1, 32'h0102_0304},
        '{"192.168.1.10",    1'b0, 1'b0, 32'h0},
        '{"10.0.100.200",    1'b0, 1'b0, 32'h0},
        '{"9.99.199.249",    1'b0, 1'b0, 32'h0},
        '{"256.1.1.1",       1'b1, 1'b0, 32'h0},
        '{"1.1.1.256",       1'b1, 1'b0, 32'h0},
        '{"999.1.1.1",       1'b1, 1'b0, 32'h0},
        '{"01.1.1.1",        1'b1, 1'b0, 32'h0},
        '{"1.1.1.00",        1'b1, 1'b0, 32'h0},
        '{"1234.1.1.1",      1'b1, 1'b0, 32'h0},
        '{".1.1.1",          1'b1, 1'b0, 32'h0},
        '{"1..1.1",          1'b1, 1'b0, 32'h0},
        '{"1.1.1.1.",        1'b1, 1'b0, 32'h0},
        '{"1.2.3.4.5",       1'b1, 1'b0, 32'h0},
        '{"1.1.1",           1'b1, 1'b0, 32'h0},
        '{"1.1.1.1 ",        1'b1, 1'b0, 32'h0},
        '{"1.a.1.1",         1'b1, 1'b0, 32'h0},
        '{"1.1.1/1",         1'b1, 1'b0, 32'h0},
        '{"1:1.1.1",         1'b1, 1'b0, 32'h0},
        '{"x1.2.3.4",        1'b1, 1'b0, 32'h0}
    };

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("[ipv4_dotted_decimal_parser_unit] ERROR");
        $finish;
    end

    // Advances the parse state by one word; returns 1 with the address word
    // when the word is an end marker.
    function automatic bit parse_word(input logic [7:0] ch, input logic eot,
                                      output addr_result_t res);
        logic part_good;
        part_good = (dig_cnt != 2'd0) && !(lead_zero && dig_cnt != 2'd1)
                    && (prt_val <= ipv4_dp_pkg::OCTET_MAX);
        res = '0;
        if (eot) begin
            res.ok = !text_bad && prt_idx == 2'd3 && part_good;
            if (res.ok) res.addr = {octets_done, prt_val[7:0]};
            prt_idx     = '0;
            prt_val     = '0;
            dig_cnt     = '0;
            lead_zero   = 1'b0;
            octets_done = '0;
            text_bad    = 1'b0;
            return 1'b1;
        end
        if (text_bad) return 1'b0;
        if (ch >= ipv4_dp_pkg::CH_ZERO && ch <= ipv4_dp_pkg::CH_NINE) begin
            if (dig_cnt == 2'd3) begin
                text_bad = 1'b1;
            end else begin
                if (dig_cnt == 2'd0) lead_zero = (ch == ipv4_dp_pkg::CH_ZERO);
                prt_val = prt_val * 10'd10 + 10'(ch - ipv4_dp_pkg::CH_ZERO);
                dig_cnt++;
            end
        end else if (ch == ipv4_dp_pkg::CH_DOT) begin
            if (!part_good || prt_idx == 2'd3) begin
                text_bad = 1'b1;
            end else begin
                octets_done = {octets_done[15:0], prt_val[7:0]};
                prt_idx++;
                prt_val   = '0;
                dig_cnt   = '0;
                lead_zero = 1'b0;
            end
        end else begin
            text_bad = 1'b1;
        end
        return 1'b0;
    endfunction

    // words are sampled before the edge updates anything
    always @(posedge aclk) begin : word_monitor
        addr_result_t   predicted;
        pinned_result_t pinned;
        addr_result_t   want;
        if (aresetn) begin
            if (s_tvalid && s_tready && parse_word(s_tdata, s_tlast, predicted)) begin
                if (pinned_q.size() != 0) begin
                    pinned = pinned_q.pop_front();
                    if (pinned.fixed) predicted = pinned.res;
                end
                addr_expect_q.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                if (addr_expect_q.size() == 0) begin
                    $error("unexpected output word: valid_res %0b address %08h",
                           m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = addr_expect_q.pop_front();
                    if (m_tuser !== want.ok) begin
                        $error("valid_res: expected %0b, got %0b", want.ok, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== want.addr) begin
                        $error("address: expected %08h, got %08h", want.addr, m_tdata);
                        fail_count++;
                    end
                end
            end
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, rx_idle ? 16 : 64)) @(posedge aclk);
            end
        end
    end

    task automatic send_word(input logic [7:0] ch, input logic eot);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // pin is queued ahead of the end marker so the monitor sees it in order
    task automatic send_text(input bit directed, input pinned_result_t pin);
        foreach (text_q[i]) send_word(text_q[i], 1'b0);
        if (directed) pinned_q.push_back(pin);
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic int unsigned pick_octet();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            2:       return $urandom_range(0, 9);
            3:       return $urandom_range(10, 99);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic void put_num(input int unsigned v);
        if (v >= 100) text_q.push_back(ipv4_dp_pkg::CH_ZERO + 8'(v / 100));
        if (v >= 10) text_q.push_back(ipv4_dp_pkg::CH_ZERO + 8'((v / 10) % 10));
        text_q.push_back(ipv4_dp_pkg::CH_ZERO + 8'(v % 10));
    endfunction

    function automatic void put_at(input int unsigned pos, input logic [7:0] ch);
        if (pos >= text_q.size()) text_q.push_back(ch);
        else text_q.insert(pos, ch);
    endfunction

    // half well-formed quads; the rest are empty or damaged, most in one place
    function automatic void build_text();
        int unsigned kind;
        int unsigned big_part;
        int unsigned pos;
        text_q.delete();
        kind     = $urandom_range(0, 15);
        big_part = (kind == 15) ? $urandom_range(0, 3) : 4;
        if (kind == 0) return;   // empty text
        for (int p = 0; p < 4; p++) begin
            if (p != 0) text_q.push_back(ipv4_dp_pkg::CH_DOT);
            put_num(p == big_part ? $urandom_range(256, 999) : pick_octet());
        end
        pos = $urandom_range(0, text_q.size());
        case (kind)
            9:  put_at(pos, 8'($urandom_range(0, 255)));
            10: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
            11: put_at(pos, ipv4_dp_pkg::CH_DOT);
            12: put_at(pos, ipv4_dp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            13: text_q.delete($urandom_range(0, text_q.size() - 1));
            14: begin
                text_q.push_back(ipv4_dp_pkg::CH_DOT);
                put_num(pick_octet());
            end
            default: ;
        endcase
        // leading zero on the first part now and then
        if (kind == 12 && $urandom_range(0, 1) == 0) put_at(0, ipv4_dp_pkg::CH_ZERO);
    endfunction

    initial begin
        pinned_result_t pin;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        prt_idx     = '0;
        prt_val     = '0;
        dig_cnt     = '0;
        lead_zero   = 1'b0;
        octets_done = '0;
        text_bad    = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        foreach (text_rows[r]) begin
            text_q.delete();
            for (int i = 0; i < text_rows[r].text.len(); i++)
                text_q.push_back(text_rows[r].text[i]);
            pin = '{text_rows[r].fixed, '{text_rows[r].ok, text_rows[r].addr}};
            send_text(1'b1, pin);
        end

        // sender waits for the block to drain
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (addr_expect_q.size() != 0) @(posedge aclk);

        // back-to-back texts into a stalled output
        tx_idle     = 1'b0;
        rx_hold_req = 1'b1;
        repeat (16) begin
            build_text();
            send_text(1'b0, '0);
        end

        tx_idle = 1'b1;
        while (words_sent < MAIN_WORDS) begin
            build_text();
            send_text(1'b0, '0);
        end

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        while (words_sent < TOTAL_WORDS) begin
            build_text();
            send_text(1'b0, '0);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (addr_expect_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ipv4_dotted_decimal_parser_unit] OK");
        end else begin
            $display("[ipv4_dotted_decimal_parser_unit] ERROR");
        end
        $finish;
    end

endmodule
